// ----- rtl/mpfd_pkg.sv -----
// shared types, codes and sizes for the page framebuffer drawing block
`default_nettype none

package mpfd_pkg;

   localparam int DEF_PANEL_WIDTH  = 128;
   localparam int DEF_PANEL_HEIGHT = 64;

   // page readout: sixteen words of eight column bytes
   localparam int WORDS_OUT = 16;
   localparam int COL_W     = 7;
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(WORDS_OUT * 8 - 1);

   localparam int PC_W = 5;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_RECT  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      JMP_NEXT        = 3'd0,
      JMP_ALWAYS      = 3'd1,
      JMP_DISPATCH    = 3'd2,
      JMP_I_GE_W      = 3'd3,
      JMP_I_GE_H      = 3'd4,
      JMP_A_NOTLAST   = 3'd5,
      JMP_COL_NOTLAST = 3'd6
   } jmp_type;

   typedef enum logic [1:0] {
      XS_BASE = 2'd0,
      XS_CUR  = 2'd1,
      XS_END  = 2'd2
   } xsel_type;

   typedef enum logic [1:0] {
      YS_BASE = 2'd0,
      YS_CUR  = 2'd1,
      YS_END  = 2'd2
   } ysel_type;

   typedef enum logic [2:0] {
      MEM_NONE     = 3'd0,
      MEM_PLOT_RD  = 3'd1,
      MEM_PLOT_WR  = 3'd2,
      MEM_CLEAR_WR = 3'd3,
      MEM_PAGE_RD  = 3'd4,
      MEM_PAGE_CAP = 3'd5
   } mem_type;

   typedef enum logic [2:0] {
      CNT_NONE    = 3'd0,
      CNT_CLR_I   = 3'd1,
      CNT_INC_I   = 3'd2,
      CNT_CLR_A   = 3'd3,
      CNT_INC_A   = 3'd4,
      CNT_CLR_COL = 3'd5,
      CNT_INC_COL = 3'd6
   } cnt_type;

   typedef struct packed {
      jmp_type         jmp;
      logic [PC_W-1:0] target;
      xsel_type        xsel;
      ysel_type        ysel;
      mem_type         mem;
      cnt_type         cnt;
      logic            idle;
   } ctrl_word_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   i_ge_w;
      logic   i_ge_h;
      logic   a_notlast;
      logic   col_notlast;
   } seq_status_type;

   // program entry points
   localparam logic [PC_W-1:0] PC_IDLE       = 5'd0;
   localparam logic [PC_W-1:0] PC_PIXEL      = 5'd1;
   localparam logic [PC_W-1:0] PC_RECT       = 5'd3;
   localparam logic [PC_W-1:0] PC_RECT_TOP   = 5'd4;
   localparam logic [PC_W-1:0] PC_RECT_SINIT = 5'd9;
   localparam logic [PC_W-1:0] PC_RECT_SIDE  = 5'd10;
   localparam logic [PC_W-1:0] PC_CLEAR      = 5'd15;
   localparam logic [PC_W-1:0] PC_CLEAR_LOOP = 5'd16;
   localparam logic [PC_W-1:0] PC_PAGE       = 5'd18;
   localparam logic [PC_W-1:0] PC_PAGE_RD    = 5'd19;

endpackage

`default_nettype wire

// ----- rtl/mono_page_framebuffer_draw.sv -----
// top level: monochrome page framebuffer with pixel, outline, clear and page read
//
// Commands enter on start when busy is low; the req_ fields are sampled at that
// edge and busy rises until the command is done. Only the page read answers:
// sixteen 64-bit words on the rsp_ ports, each for one cycle under rsp_strobe,
// word_index 0 to 15, last on the final one. The receiver cannot hold words off.
// A small microprogram steps a datapath around one byte-wide store, one pixel
// being a read then a write of its byte on the single port pair.
// The clear sweep writes zero to every byte of the store, depth = PANEL_WIDTH *
// ceil(PANEL_HEIGHT/8); a page read fetches then captures each of its bytes in turn.
// Reset starts the same clearing sweep over the store, with busy high, before the
// first command is taken.
`default_nettype none

module mono_page_framebuffer_draw
   import mpfd_pkg::*;
#(
   parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_op,
   input  wire logic signed [8:0] req_x,
   input  wire logic signed [8:0] req_y,
   input  wire logic [7:0]        req_width,
   input  wire logic [7:0]        req_height,
   input  wire logic              req_on,
   input  wire logic [2:0]        req_page,
   output logic                   rsp_strobe,
   output logic [63:0]            rsp_page_word,
   output logic [3:0]             rsp_word_index,
   output logic                   rsp_last
);

   localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
   localparam int DEPTH      = PANEL_WIDTH * PAGE_COUNT;
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] A_LAST = AW'(DEPTH - 1);

   ctrl_word_type  cw;
   seq_status_type status;

   logic              accept;
   logic signed [8:0] x_ff;
   logic signed [8:0] y_ff;
   logic [7:0]        w_ff;
   logic [7:0]        h_ff;
   logic              on_ff;
   logic [2:0]        page_ff;

   logic [7:0]       i_ff;
   logic [AW-1:0]    a_ff;
   logic [COL_W-1:0] col_ff;

   logic [10:0] x_ext, y_ext, xc, yc;
   logic        plot_ok;
   logic [11:0] plot_addr_wide;
   logic [AW-1:0] plot_addr_ff;
   logic        plot_ok_ff;
   logic [2:0]  plot_bit_ff;
   logic [7:0]  plot_mask;

   logic [11:0] page_addr_wide;
   logic        page_ok, col_ok;
   logic [7:0]  cap_byte;
   logic [55:0] word_ff;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   logic        rsp_strobe_ff;
   logic [63:0] rsp_page_word_ff;
   logic [3:0]  rsp_word_index_ff;
   logic        rsp_last_ff;

   assign busy   = !cw.idle;
   assign accept = start && cw.idle;

   assign status.start       = start;
   assign status.op          = op_type'(req_op);
   assign status.i_ge_w      = (i_ff >= w_ff);
   assign status.i_ge_h      = (i_ff >= h_ff);
   assign status.a_notlast   = (a_ff != A_LAST);
   assign status.col_notlast = (col_ff != COL_LAST);

   mpfd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   // command fields
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_x;
         y_ff    <= req_y;
         w_ff    <= req_width;
         h_ff    <= req_height;
         on_ff   <= req_on;
         page_ff <= req_page;
      end
   end

   // loop counters
   always_ff @(posedge clock) begin
      unique case (cw.cnt)
         CNT_NONE:    ;
         CNT_CLR_I:   i_ff   <= '0;
         CNT_INC_I:   i_ff   <= i_ff + 1'b1;
         CNT_CLR_A:   a_ff   <= '0;
         CNT_INC_A:   a_ff   <= a_ff + 1'b1;
         CNT_CLR_COL: col_ff <= '0;
         CNT_INC_COL: col_ff <= col_ff + 1'b1;
         default:     ;
      endcase
   end

   // pixel coordinates in 11-bit two's complement
   assign x_ext = {{2{x_ff[8]}}, x_ff};
   assign y_ext = {{2{y_ff[8]}}, y_ff};

   always_comb begin
      unique case (cw.xsel)
         XS_BASE: xc = x_ext;
         XS_CUR:  xc = x_ext + {3'b000, i_ff};
         XS_END:  xc = x_ext + {3'b000, w_ff} - 11'd1;
         default: xc = x_ext;
      endcase
      unique case (cw.ysel)
         YS_BASE: yc = y_ext;
         YS_CUR:  yc = y_ext + {3'b000, i_ff};
         YS_END:  yc = y_ext + {3'b000, h_ff} - 11'd1;
         default: yc = y_ext;
      endcase
   end

   assign plot_ok = !xc[10] && (xc[9:0] < 10'(PANEL_WIDTH)) &&
                    !yc[10] && (yc[9:0] < 10'(PANEL_HEIGHT));
   assign plot_addr_wide = 12'(xc[7:0]) + 12'(yc[5:3]) * 12'(PANEL_WIDTH);

   always_ff @(posedge clock) begin
      if (cw.mem == MEM_PLOT_RD) begin
         plot_addr_ff <= plot_addr_wide[AW-1:0];
         plot_ok_ff   <= plot_ok;
         plot_bit_ff  <= yc[2:0];
      end
   end

   assign plot_mask = 8'(1) << plot_bit_ff;

   // page readout addressing; bytes off the panel read as zero
   assign page_addr_wide = 12'(page_ff) * 12'(PANEL_WIDTH) + 12'(col_ff);
   assign page_ok  = (4'(page_ff) < 4'(PAGE_COUNT));
   assign col_ok   = ({2'b00, col_ff} < 9'(PANEL_WIDTH));
   assign cap_byte = (page_ok && col_ok) ? ram_rd_data : 8'd0;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = plot_addr_ff;
      ram_wr_data = 8'd0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = plot_addr_wide[AW-1:0];
      unique case (cw.mem)
         MEM_NONE: ;
         MEM_PLOT_RD: begin
            ram_rd_en = plot_ok;
         end
         MEM_PLOT_WR: begin
            ram_wr_en   = plot_ok_ff;
            ram_wr_data = on_ff ? (ram_rd_data | plot_mask) : (ram_rd_data & ~plot_mask);
         end
         MEM_CLEAR_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = a_ff;
         end
         MEM_PAGE_RD: begin
            ram_rd_en   = page_ok && col_ok;
            ram_rd_addr = page_addr_wide[AW-1:0];
         end
         MEM_PAGE_CAP: ;
         default: ;
      endcase
   end

   mpfd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // word assembly, the eighth byte completes a word
   always_ff @(posedge clock) begin
      if (cw.mem == MEM_PAGE_CAP) begin
         if (col_ff[2:0] == 3'd7) begin
            rsp_page_word_ff  <= {cap_byte, word_ff};
            rsp_word_index_ff <= col_ff[6:3];
            rsp_last_ff       <= &col_ff[6:3];
         end else begin
            word_ff[{col_ff[2:0], 3'b000} +: 8] <= cap_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (cw.mem == MEM_PAGE_CAP) && (col_ff[2:0] == 3'd7);
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_page_word  = rsp_page_word_ff;
   assign rsp_word_index = rsp_word_index_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/mpfd_ram.sv -----
// generic single write, single read ram with registered read data
`default_nettype none

module mpfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/mpfd_seq.sv -----
// microcode rom and step counter of the drawing sequencer
`default_nettype none

module mpfd_seq
   import mpfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire seq_status_type status,
   output ctrl_word_type       cw
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;

   function automatic ctrl_word_type mk(input jmp_type jmp, input logic [PC_W-1:0] target,
                                        input xsel_type xs, input ysel_type ys,
                                        input mem_type mem, input cnt_type cnt);
      ctrl_word_type w;
      w.jmp    = jmp;
      w.target = target;
      w.xsel   = xs;
      w.ysel   = ys;
      w.mem    = mem;
      w.cnt    = cnt;
      w.idle   = 1'b0;
      return w;
   endfunction

   function automatic ctrl_word_type rom_word(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc)
         // wait for a command
         5'd0: begin
            w = mk(JMP_DISPATCH, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_NONE);
            w.idle = 1'b1;
         end
         // single pixel
         5'd1:  w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_BASE, MEM_PLOT_RD, CNT_NONE);
         5'd2:  w = mk(JMP_ALWAYS, PC_IDLE, XS_BASE, YS_BASE, MEM_PLOT_WR, CNT_NONE);
         // rectangle: top and bottom edges
         5'd3:  w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_CLR_I);
         5'd4:  w = mk(JMP_I_GE_W, PC_RECT_SINIT, XS_BASE, YS_BASE, MEM_NONE, CNT_NONE);
         5'd5:  w = mk(JMP_NEXT, PC_IDLE, XS_CUR, YS_BASE, MEM_PLOT_RD, CNT_NONE);
         5'd6:  w = mk(JMP_NEXT, PC_IDLE, XS_CUR, YS_BASE, MEM_PLOT_WR, CNT_NONE);
         5'd7:  w = mk(JMP_NEXT, PC_IDLE, XS_CUR, YS_END, MEM_PLOT_RD, CNT_NONE);
         5'd8:  w = mk(JMP_ALWAYS, PC_RECT_TOP, XS_CUR, YS_END, MEM_PLOT_WR, CNT_INC_I);
         // rectangle: left and right edges
         5'd9:  w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_CLR_I);
         5'd10: w = mk(JMP_I_GE_H, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_NONE);
         5'd11: w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_CUR, MEM_PLOT_RD, CNT_NONE);
         5'd12: w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_CUR, MEM_PLOT_WR, CNT_NONE);
         5'd13: w = mk(JMP_NEXT, PC_IDLE, XS_END, YS_CUR, MEM_PLOT_RD, CNT_NONE);
         5'd14: w = mk(JMP_ALWAYS, PC_RECT_SIDE, XS_END, YS_CUR, MEM_PLOT_WR, CNT_INC_I);
         // clear sweep, also run after reset
         5'd15: w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_CLR_A);
         5'd16: w = mk(JMP_A_NOTLAST, PC_CLEAR_LOOP, XS_BASE, YS_BASE, MEM_CLEAR_WR,
                       CNT_INC_A);
         5'd17: w = mk(JMP_ALWAYS, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_NONE);
         // page readout, each byte a read step then a capture step
         5'd18: w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_CLR_COL);
         5'd19: w = mk(JMP_NEXT, PC_IDLE, XS_BASE, YS_BASE, MEM_PAGE_RD, CNT_NONE);
         5'd20: w = mk(JMP_COL_NOTLAST, PC_PAGE_RD, XS_BASE, YS_BASE, MEM_PAGE_CAP,
                       CNT_INC_COL);
         5'd21: w = mk(JMP_ALWAYS, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_NONE);
         default: w = mk(JMP_ALWAYS, PC_IDLE, XS_BASE, YS_BASE, MEM_NONE, CNT_NONE);
      endcase
      return w;
   endfunction

   assign cw = rom_word(pc_ff);

   always_comb begin
      pc_in = pc_ff + 1'b1;
      unique case (cw.jmp)
         JMP_NEXT:        pc_in = pc_ff + 1'b1;
         JMP_ALWAYS:      pc_in = cw.target;
         JMP_DISPATCH: begin
            if (status.start) begin
               unique case (status.op)
                  OP_PIXEL: pc_in = PC_PIXEL;
                  OP_RECT:  pc_in = PC_RECT;
                  OP_CLEAR: pc_in = PC_CLEAR;
                  OP_READ:  pc_in = PC_PAGE;
                  default:  pc_in = PC_IDLE;
               endcase
            end else begin
               pc_in = cw.target;
            end
         end
         JMP_I_GE_W:      if (status.i_ge_w) pc_in = cw.target;
         JMP_I_GE_H:      if (status.i_ge_h) pc_in = cw.target;
         JMP_A_NOTLAST:   if (status.a_notlast) pc_in = cw.target;
         JMP_COL_NOTLAST: if (status.col_notlast) pc_in = cw.target;
         default:         pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ----- test/mono_page_framebuffer_draw_test.sv -----
// self-checking test of the page framebuffer: directed table, then random drawing and page reads
module mono_page_framebuffer_draw_test;
   import mpfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PANEL_W      = DEF_PANEL_WIDTH;
   localparam int PANEL_H      = DEF_PANEL_HEIGHT;
   localparam int PAGE_COUNT   = (PANEL_H + 7) / 8;
   localparam int STORE_DEPTH  = PANEL_W * PAGE_COUNT;
   localparam int RANDOM_ITEMS = 185;
   localparam int STALL_LIMIT  = 12000;
   localparam int DRAIN_CYCLES = 300;
   localparam int SCRIPT_LEN   = 25;

   typedef struct packed {
      op_type op;
      int     x;
      int     y;
      int     w;
      int     h;
      bit     on;
      int     page;
   } command_type;

   // typed rows carry their page readout: first word as given, all others zero
   typedef struct packed {
      command_type cmd;
      bit          typed;
      logic [63:0] first_word;
   } script_row_type;

   typedef struct packed {
      logic [63:0] page_word;
      logic [3:0]  word_index;
      logic        last;
   } page_word_type;

   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 0}, 1'b1, 64'h0},
      '{'{OP_PIXEL, 0,    0,    0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 0}, 1'b1, 64'h1},
      '{'{OP_PIXEL, 127,  63,   0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 7}, 1'b0, 64'h0},
      '{'{OP_PIXEL, 0,    0,    0,   0,   1'b0, 0}, 1'b0, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 0}, 1'b1, 64'h0},
      '{'{OP_PIXEL, -256, -256, 0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_PIXEL, 255,  255,  0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_PIXEL, 128,  5,    0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_PIXEL, 5,    64,   0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_PIXEL, -1,   3,    0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_RECT,  -5,   -3,   20,  15,  1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_RECT,  10,   20,   0,   5,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_RECT,  30,   40,   6,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_RECT,  60,   10,   0,   0,   1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_RECT,  0,    0,    255, 255, 1'b1, 0}, 1'b0, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 0}, 1'b0, 64'h0},
      '{'{OP_RECT,  -200, -200, 255, 255, 1'b0, 0}, 1'b0, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 6}, 1'b0, 64'h0},
      '{'{OP_RECT,  100,  50,   1,   1,   1'b0, 0}, 1'b0, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 6}, 1'b0, 64'h0},
      '{'{OP_CLEAR, 0,    0,    0,   0,   1'b0, 0}, 1'b0, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 3}, 1'b1, 64'h0},
      '{'{OP_READ,  0,    0,    0,   0,   1'b0, 7}, 1'b1, 64'h0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_op = '0;
   logic signed [8:0] req_x = '0;
   logic signed [8:0] req_y = '0;
   logic [7:0]        req_width = '0;
   logic [7:0]        req_height = '0;
   logic              req_on = 1'b0;
   logic [2:0]        req_page = '0;
   logic              rsp_strobe;
   logic [63:0]       rsp_page_word;
   logic [3:0]        rsp_word_index;
   logic              rsp_last;

   logic [7:0] frame_bytes [STORE_DEPTH];
   page_word_type expected_words [$];
   int failures = 0;
   int stall_cycles = 0;

   mono_page_framebuffer_draw u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_x          (req_x),
      .req_y          (req_y),
      .req_width      (req_width),
      .req_height     (req_height),
      .req_on         (req_on),
      .req_page       (req_page),
      .rsp_strobe     (rsp_strobe),
      .rsp_page_word  (rsp_page_word),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_failure(string msg);
      if (failures < 10) begin
         $display("mismatch: %s", msg);
      end
      failures++;
   endtask

   function automatic void set_pixel(int px, int py, bit on_bit);
      int idx;
      if (px < 0 || px >= PANEL_W || py < 0 || py >= PANEL_H) return;
      idx = px + (py / 8) * PANEL_W;
      frame_bytes[idx][py % 8] = on_bit;
   endfunction

   // updates the frame copy; a page read queues its sixteen words
   function automatic void execute_on_frame(command_type c);
      page_word_type w;
      logic [63:0]   bits;
      int            col;
      case (c.op)
         OP_PIXEL: set_pixel(c.x, c.y, c.on);
         OP_RECT: begin
            // zero width or height still draws the other pair of edges
            for (int i = c.x; i < c.x + c.w; i++) begin
               set_pixel(i, c.y, c.on);
               set_pixel(i, c.y + c.h - 1, c.on);
            end
            for (int i = c.y; i < c.y + c.h; i++) begin
               set_pixel(c.x, i, c.on);
               set_pixel(c.x + c.w - 1, i, c.on);
            end
         end
         OP_CLEAR: foreach (frame_bytes[i]) frame_bytes[i] = '0;
         default: begin
            for (int k = 0; k < WORDS_OUT; k++) begin
               bits = '0;
               for (int b = 0; b < 8; b++) begin
                  col = k * 8 + b;
                  if (c.page < PAGE_COUNT && col < PANEL_W)
                     bits[b*8 +: 8] = frame_bytes[c.page * PANEL_W + col];
               end
               w.page_word  = bits;
               w.word_index = 4'(k);
               w.last       = (k == WORDS_OUT - 1);
               expected_words.push_back(w);
            end
         end
      endcase
   endfunction

   // leaves start high; returns at the edge that takes the command
   task automatic send_command(command_type c);
      req_op     <= c.op;
      req_x      <= 9'(c.x);
      req_y      <= 9'(c.y);
      req_width  <= 8'(c.w);
      req_height <= 8'(c.h);
      req_on     <= c.on;
      req_page   <= 3'(c.page);
      start      <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_words;
      start <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int pick_coord(int span);
      if ($urandom_range(3) != 0) return int'($urandom_range(span + 7)) - 8;
      return int'($urandom_range(511)) - 256;
   endfunction

   function automatic int pick_size;
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(12);
      if (r < 95) return $urandom_range(80);
      return $urandom_range(255);
   endfunction

   initial begin
      command_type   c;
      page_word_type w;
      int            r;
      bit            steady;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_command(SCRIPT[i].cmd);
         if (SCRIPT[i].typed) begin
            for (int k = 0; k < WORDS_OUT; k++) begin
               w.page_word  = (k == 0) ? SCRIPT[i].first_word : 64'h0;
               w.word_index = 4'(k);
               w.last       = (k == WORDS_OUT - 1);
               expected_words.push_back(w);
            end
         end else begin
            execute_on_frame(SCRIPT[i].cmd);
         end
         idle_for(pick_gap(1'b0));
      end

      steady = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 20 == 0) steady = ($urandom_range(3) == 0);
         r = $urandom_range(99);
         if (r < 45) c.op = OP_PIXEL;
         else if (r < 75) c.op = OP_RECT;
         else if (r < 78) c.op = OP_CLEAR;
         else c.op = OP_READ;
         c.x    = pick_coord(PANEL_W);
         c.y    = pick_coord(PANEL_H);
         c.w    = pick_size();
         c.h    = pick_size();
         c.on   = ($urandom_range(9) < 7);
         c.page = $urandom_range(7);
         send_command(c);
         execute_on_frame(c);
         // hold off now and then until the page read has fully drained
         if (n % 50 == 49) wait_for_words();
         else idle_for(pick_gap(steady));
      end

      wait_for_words();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         note_failure($sformatf("%0d words never arrived", expected_words.size()));
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin
      page_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            note_failure($sformatf("unexpected word index %0d data %h",
                                   rsp_word_index, rsp_page_word));
         end else begin
            want = expected_words.pop_front();
            if (rsp_page_word !== want.page_word)
               note_failure($sformatf("word %0d data expected %h got %h",
                                      want.word_index, want.page_word, rsp_page_word));
            if (rsp_word_index !== want.word_index)
               note_failure($sformatf("word_index expected %0d got %0d",
                                      want.word_index, rsp_word_index));
            if (rsp_last !== want.last)
               note_failure($sformatf("word %0d last expected %b got %b",
                                      want.word_index, want.last, rsp_last));
         end
      end
   end

   // nothing taken and no word out for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

// ----- files.f -----
rtl/mpfd_pkg.sv
rtl/mpfd_ram.sv
rtl/mpfd_seq.sv
rtl/mono_page_framebuffer_draw.sv
test/mono_page_framebuffer_draw_test.sv
